/* hw/rtl/trs_pkg.sv */
// Shared types, constants and coefficient tables for the trackball rotate and scroll core.
`default_nettype none

package trs_pkg;

	localparam int ACCUM_WIDTH_DEF    = 16;
	localparam int TRIG_FRAC_BITS_DEF = 14;

	// configuration register indexes
	localparam logic [1:0] REG_ROTATION_INDEX = 2'd0;
	localparam logic [1:0] REG_SCROLL_DIVIDER = 2'd1;
	localparam logic [1:0] REG_SCROLL_NEGATE  = 2'd2;
	localparam logic [1:0] REG_SCROLL_MODE    = 2'd3;

	localparam int CFG_DATA_W = 4;

	localparam logic [3:0] ROT_INDEX_MAX = 4'd8;
	localparam logic [3:0] ROT_INDEX_MID = 4'd4;   // zero degrees
	localparam logic [3:0] ROT_INDEX_RST = 4'd1;
	localparam logic [2:0] DIV_INDEX_MAX = 3'd5;
	localparam logic [2:0] DIV_INDEX_RST = 3'd4;

	localparam logic [2:0] SHIFT_TABLE [6] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6};

	// cos and sin of 0, 15, 30, 45, 60 degrees at 24 fraction bits
	localparam logic [63:0] COS_Q24 [5] = '{
		64'd16777216, 64'd16205546, 64'd14529495, 64'd11863283, 64'd8388608};
	localparam logic [63:0] SIN_Q24 [5] = '{
		64'd0, 64'd4342263, 64'd8388608, 64'd11863283, 64'd14529495};

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [3:0] rotation_index;
		logic [2:0] scroll_divider_index;
		logic       scroll_negate;
		logic       scroll_mode;
	} cfg_t;

	// one rotated report, classified by dominant axis
	typedef struct packed {
		logic signed [7:0] rx;
		logic signed [7:0] ry;
		logic signed [7:0] wheel_h;
		logic signed [7:0] wheel_v;
		logic              lock_x;
	} entry_t;

	// round half up from 24 fraction bits down to frac bits; magnitude only
	function automatic logic [16:0] round_coef(input logic [63:0] v24, input int frac);
		logic [63:0] v;
		v = (v24 << frac) + (64'd1 << 23);
		return v[40:24];
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/trs_front.sv */
// Front end: accepts reports, rotates the motion and classifies the dominant axis.
`default_nettype none

module trs_front #(
	parameter int TRIG_FRAC_BITS = trs_pkg::TRIG_FRAC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire trs_pkg::cfg_t       cfg,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic signed [7:0]   motion_x,
	input  wire logic signed [7:0]   motion_y,
	input  wire logic signed [7:0]   wheel_h,
	input  wire logic signed [7:0]   wheel_v,
	output logic                     push,
	output trs_pkg::entry_t          push_data,
	input  wire logic                full
);
	import trs_pkg::*;

	localparam int CW = TRIG_FRAC_BITS + 2;
	localparam int PW = CW + 8;
	localparam int SW = PW + 1;
	localparam logic signed [SW-1:0] TRUNC_BIAS = SW'((64'd1 << TRIG_FRAC_BITS) - 64'd1);
	localparam logic signed [SW-1:0] SAT_MAX = SW'(127);
	localparam logic signed [SW-1:0] SAT_MIN = SW'(-128);

	logic [3:0]              ri_sat;
	logic [2:0]              k;
	logic [16:0]             cos_full, sin_full;
	logic signed [CW-1:0]    c_s, s_s;

	logic                    valid_s1;
	logic signed [PW-1:0]    pxc_s1, pys_s1, pxs_s1, pyc_s1;
	logic signed [7:0]       wh_s1, wv_s1;

	logic signed [SW-1:0]    sum_x, sum_y;
	logic signed [7:0]       rx, ry;
	logic [8:0]              ax, ay;

	function automatic logic signed [7:0] trunc_sat(input logic signed [SW-1:0] s);
		logic signed [SW-1:0] t;
		t = (s < 0) ? ((s + TRUNC_BIAS) >>> TRIG_FRAC_BITS) : (s >>> TRIG_FRAC_BITS);
		if (t > SAT_MAX) begin
			return 8'sd127;
		end else if (t < SAT_MIN) begin
			return -8'sd128;
		end
		return t[7:0];
	endfunction

	// coefficient selection
	always_comb begin
		ri_sat = (cfg.rotation_index > ROT_INDEX_MAX) ? ROT_INDEX_MAX : cfg.rotation_index;
		k = (ri_sat >= ROT_INDEX_MID) ? 3'(ri_sat - ROT_INDEX_MID) :
			3'(ROT_INDEX_MID - ri_sat);
		cos_full = round_coef(COS_Q24[k], TRIG_FRAC_BITS);
		sin_full = round_coef(SIN_Q24[k], TRIG_FRAC_BITS);
		c_s = CW'({1'b0, cos_full[TRIG_FRAC_BITS:0]});
		s_s = CW'({1'b0, sin_full[TRIG_FRAC_BITS:0]});
		// negative table angles flip the sine
		if (ri_sat < ROT_INDEX_MID) begin
			s_s = -s_s;
		end
	end

	assign in_ready = !valid_s1 || !full;
	assign push     = valid_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pxc_s1 <= PW'(motion_x) * PW'(c_s);
			pys_s1 <= PW'(motion_y) * PW'(s_s);
			pxs_s1 <= PW'(motion_x) * PW'(s_s);
			pyc_s1 <= PW'(motion_y) * PW'(c_s);
			wh_s1  <= wheel_h;
			wv_s1  <= wheel_v;
		end
	end

	always_comb begin
		sum_x = SW'(pxc_s1) + SW'(pys_s1);
		sum_y = SW'(pyc_s1) - SW'(pxs_s1);
		rx = trunc_sat(sum_x);
		ry = trunc_sat(sum_y);
		ax = rx[7] ? 9'(-{rx[7], rx}) : 9'({rx[7], rx});
		ay = ry[7] ? 9'(-{ry[7], ry}) : 9'({ry[7], ry});
		push_data.rx      = rx;
		push_data.ry      = ry;
		push_data.wheel_h = wh_s1;
		push_data.wheel_v = wv_s1;
		push_data.lock_x  = ax > ay;   // ties lock to vertical
	end

endmodule

`default_nettype wire

/* hw/rtl/trs_queue.sv */
// Short item queue between the front end and the scroll back end.
`default_nettype none

module trs_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire trs_pkg::entry_t push_data,
	output logic                 full,
	input  wire logic            pop,
	output trs_pkg::entry_t      pop_data,
	output logic                 empty
);
	import trs_pkg::*;

	entry_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]   count_q;

	assign full     = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					QUEUE_PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					QUEUE_PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= QUEUE_CNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= QUEUE_CNT_W'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop)) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QUEUE_CNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

/* hw/rtl/trs_back.sv */
// Back end: scroll accumulation, wheel clamping and the output register.
`default_nettype none

module trs_back #(
	parameter int ACCUM_WIDTH = trs_pkg::ACCUM_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire trs_pkg::cfg_t     cfg,
	input  wire logic              empty,
	input  wire trs_pkg::entry_t   pop_data,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic signed [7:0]      out_x,
	output logic signed [7:0]      out_y,
	output logic signed [7:0]      out_h,
	output logic signed [7:0]      out_v
);
	import trs_pkg::*;

	localparam int AW = ACCUM_WIDTH;
	localparam logic signed [AW:0] WHEEL_MAX = (AW+1)'(127);
	localparam logic signed [AW:0] WHEEL_MIN = (AW+1)'(-127);

	logic                    out_valid_q;
	logic signed [7:0]       out_x_q, out_y_q, out_h_q, out_v_q;

	logic signed [AW-1:0]    acc_q   [2];
	logic signed [AW-1:0]    acc_sum [2];
	logic signed [AW-1:0]    acc_nxt [2];
	logic signed [AW-1:0]    quo     [2];
	logic signed [AW:0]      wsum    [2];
	logic signed [8:0]       add_l   [2];
	logic signed [7:0]       wheel_l [2];
	logic signed [7:0]       new_w   [2];
	logic signed [9:0]       used    [2];

	logic [2:0]              di_sat;
	logic [2:0]              shamt;
	logic signed [8:0]       dx, dy;

	assign pop       = !empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_h     = out_h_q;
	assign out_v     = out_v_q;

	always_comb begin
		di_sat = (cfg.scroll_divider_index > DIV_INDEX_MAX) ? DIV_INDEX_MAX :
			cfg.scroll_divider_index;
		shamt = SHIFT_TABLE[di_sat];
		dx = pop_data.lock_x ? 9'(pop_data.rx) : 9'sd0;
		dy = pop_data.lock_x ? 9'sd0 : 9'(pop_data.ry);
		// horizontal adds x*m, vertical adds -y*m
		add_l[0] = cfg.scroll_negate ? -dx : dx;
		add_l[1] = cfg.scroll_negate ? dy : -dy;
		wheel_l[0] = pop_data.wheel_h;
		wheel_l[1] = pop_data.wheel_v;
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		always_comb begin
			acc_sum[l] = acc_q[l] + AW'(add_l[l]);
			quo[l]     = acc_sum[l] >>> shamt;
			wsum[l]    = (AW+1)'(wheel_l[l]) + (AW+1)'(quo[l]);
			if (quo[l] == '0) begin
				new_w[l] = wheel_l[l];
			end else if (wsum[l] > WHEEL_MAX) begin
				new_w[l] = 8'sd127;
			end else if (wsum[l] < WHEEL_MIN) begin
				new_w[l] = -8'sd127;
			end else begin
				new_w[l] = wsum[l][7:0];
			end
			used[l]    = 10'(new_w[l]) - 10'(wheel_l[l]);
			acc_nxt[l] = acc_sum[l] - (AW'(used[l]) <<< shamt);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				acc_q[l] <= '0;
			end else if (pop && cfg.scroll_mode) begin
				acc_q[l] <= acc_nxt[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cfg.scroll_mode) begin
				out_x_q <= 8'sd0;
				out_y_q <= 8'sd0;
				out_h_q <= new_w[0];
				out_v_q <= new_w[1];
			end else begin
				out_x_q <= pop_data.rx;
				out_y_q <= pop_data.ry;
				out_h_q <= pop_data.wheel_h;
				out_v_q <= pop_data.wheel_v;
			end
		end
	end

`ifndef SYNTHESIS
	a_ptr_mode_acc_h: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg.scroll_mode |=> (acc_q[0] == $past(acc_q[0]) || $past(cfg.scroll_mode) != cfg.scroll_mode))
		else $error("horizontal accumulator moved in pointer mode");
	a_ptr_mode_acc_v: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg.scroll_mode |=> (acc_q[1] == $past(acc_q[1]) || $past(cfg.scroll_mode) != cfg.scroll_mode))
		else $error("vertical accumulator moved in pointer mode");
	a_scroll_zero_motion: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cfg.scroll_mode) |=> (out_x_q == 8'sd0 && out_y_q == 8'sd0))
		else $error("motion not cleared in scroll mode");
`endif

endmodule

`default_nettype wire

/* hw/rtl/trackball_rotate_and_scroll_core.sv */
// Top level of the trackball rotate and scroll core: configuration registers and wiring.
`default_nettype none

// Takes one pointer report per cycle while in_ready is high and returns one result per
// report, in order. A report is rotated in the front end (multiplies, then truncate,
// saturate and dominant-axis pick, one register stage), passes a two-entry queue, and is
// finished in the back end, whose combinational accumulator update feeds the output
// register and sustains one item per clock while out_ready is high. Configuration
// registers are written through cfg_we/cfg_index/cfg_data and should change only while the
// core holds no item; reset selects -45 degrees, shift 5, no negate, pointer mode.
module trackball_rotate_and_scroll_core #(
	parameter int ACCUM_WIDTH    = trs_pkg::ACCUM_WIDTH_DEF,
	parameter int TRIG_FRAC_BITS = trs_pkg::TRIG_FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [1:0]                     cfg_index,
	input  wire logic [trs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic signed [7:0]              motion_x,
	input  wire logic signed [7:0]              motion_y,
	input  wire logic signed [7:0]              wheel_h,
	input  wire logic signed [7:0]              wheel_v,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [7:0]                   out_x,
	output logic signed [7:0]                   out_y,
	output logic signed [7:0]                   out_h,
	output logic signed [7:0]                   out_v
);
	import trs_pkg::*;

	cfg_t    cfg_q;
	logic    push, full, pop, empty;
	entry_t  push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rotation_index       <= ROT_INDEX_RST;
			cfg_q.scroll_divider_index <= DIV_INDEX_RST;
			cfg_q.scroll_negate        <= 1'b0;
			cfg_q.scroll_mode          <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROTATION_INDEX: begin
					cfg_q.rotation_index <= cfg_data[3:0];
				end
				REG_SCROLL_DIVIDER: begin
					cfg_q.scroll_divider_index <= cfg_data[2:0];
				end
				REG_SCROLL_NEGATE: begin
					cfg_q.scroll_negate <= cfg_data[0];
				end
				REG_SCROLL_MODE: begin
					cfg_q.scroll_mode <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	trs_front #(
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.motion_x  (motion_x),
		.motion_y  (motion_y),
		.wheel_h   (wheel_h),
		.wheel_v   (wheel_v),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	trs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	trs_back #(
		.ACCUM_WIDTH(ACCUM_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.empty     (empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_h     (out_h),
		.out_v     (out_v)
	);

endmodule

`default_nettype wire

/* bench/tb_trackball_rotate_and_scroll_core.sv */
// Self-checking testbench for the trackball rotate and scroll core: random and directed reports.
`timescale 1ns / 100ps

module tb_trackball_rotate_and_scroll_core;

	localparam int FRAC_BITS   = 14;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 80;

	typedef struct {
		logic [7:0] mx;
		logic [7:0] my;
		logic [7:0] wh;
		logic [7:0] wv;
		int         gap;
		bit         drain;
	} report_in_t;

	typedef struct packed {
		logic signed [7:0] x;
		logic signed [7:0] y;
		logic signed [7:0] h;
		logic signed [7:0] v;
	} report_out_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [1:0]                     cfg_index = '0;
	logic [trs_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	logic signed [7:0]              motion_x  = '0;
	logic signed [7:0]              motion_y  = '0;
	logic signed [7:0]              wheel_h   = '0;
	logic signed [7:0]              wheel_v   = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic signed [7:0]              out_x, out_y, out_h, out_v;

	// predictor copy of the registers and accumulators
	logic [3:0]  rot_sel  = 4'd1;
	logic [2:0]  div_sel  = 3'd4;
	logic        neg_sel  = 1'b0;
	logic        scroll_on = 1'b0;
	logic [15:0] acc_h    = '0;
	logic [15:0] acc_v    = '0;

	report_in_t  report_queue[$];
	report_out_t predicted_reports[$];
	report_in_t  next_report;
	report_out_t drv_pred, mon_want, mon_got;

	int n_predicted    = 0;
	int n_checked      = 0;
	int n_fail         = 0;
	int n_configs      = 0;
	int cycle_count    = 0;
	int gap_count      = 0;
	int stall_left     = 0;
	int hold_left      = 0;
	int long_hold_req  = 0;
	int long_hold_seen = 0;
	bit tx_idle        = 1'b0;
	bit rx_idle        = 1'b0;

	trackball_rotate_and_scroll_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.motion_x  (motion_x),
		.motion_y  (motion_y),
		.wheel_h   (wheel_h),
		.wheel_v   (wheel_v),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_h     (out_h),
		.out_v     (out_v)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint cos_q24(int k);
		case (k)
			0: return 64'd16777216;
			1: return 64'd16205546;
			2: return 64'd14529495;
			3: return 64'd11863283;
			default: return 64'd8388608;
		endcase
	endfunction

	function automatic longint sin_q24(int k);
		case (k)
			0: return 64'd0;
			1: return 64'd4342263;
			2: return 64'd8388608;
			3: return 64'd11863283;
			default: return 64'd14529495;
		endcase
	endfunction

	// round half up from 24 fraction bits
	function automatic longint to_q14(longint v24);
		return (v24 * (longint'(1) << FRAC_BITS) + (longint'(1) << 23)) >>> 24;
	endfunction

	function automatic longint trunc_sat8(longint s);
		longint q;
		q = (s < 0) ? -((-s) >>> FRAC_BITS) : (s >>> FRAC_BITS);
		if (q > 127)
			q = 127;
		if (q < -128)
			q = -128;
		return q;
	endfunction

	// floor quotient of the accumulator goes onto the wheel; the used part leaves the accumulator
	function automatic logic signed [7:0] scroll_wheel(inout logic [15:0] acc,
			input logic signed [7:0] wheel, input int sh);
		longint a, q, nw, used;
		a = $signed(acc);
		q = a >>> sh;
		if (q == 0)
			return wheel;
		nw = wheel + q;
		if (nw > 127)
			nw = 127;
		else if (nw < -127)
			nw = -127;
		used = nw - wheel;
		acc = acc - 16'(used <<< sh);
		return 8'(nw);
	endfunction

	task automatic rotate_report(input report_in_t r, output report_out_t o);
		int ri, di, k;
		longint c, s, x, y, xr, yr, ax, ay, m;
		ri = (rot_sel > 4'd8) ? 8 : int'(rot_sel);
		di = (div_sel > 3'd5) ? 5 : int'(div_sel);
		k = (ri < 4) ? 4 - ri : ri - 4;
		c = to_q14(cos_q24(k));
		s = to_q14(sin_q24(k));
		if (ri < 4)
			s = -s;
		x = $signed(r.mx);
		y = $signed(r.my);
		xr = trunc_sat8(x * c + y * s);
		yr = trunc_sat8(-x * s + y * c);
		if (scroll_on) begin
			m = neg_sel ? -1 : 1;
			ax = (xr < 0) ? -xr : xr;
			ay = (yr < 0) ? -yr : yr;
			// ties keep the vertical axis
			if (ax > ay)
				yr = 0;
			else
				xr = 0;
			acc_h = acc_h + 16'(xr * m);
			acc_v = acc_v + 16'(-yr * m);
			o.h = scroll_wheel(acc_h, r.wh, di + 1);
			o.v = scroll_wheel(acc_v, r.wv, di + 1);
			o.x = '0;
			o.y = '0;
		end else begin
			o.x = 8'(xr);
			o.y = 8'(yr);
			o.h = r.wh;
			o.v = r.wv;
		end
	endtask

	// ---------------------------------------------------------------- driver

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			motion_x  <= '0;
			motion_y  <= '0;
			wheel_h   <= '0;
			wheel_v   <= '0;
			gap_count = 0;
		end else begin
			if (in_valid && in_ready) begin
				next_report.mx = motion_x;
				next_report.my = motion_y;
				next_report.wh = wheel_h;
				next_report.wv = wheel_v;
				rotate_report(next_report, drv_pred);
				predicted_reports.push_back(drv_pred);
				n_predicted++;
			end
			if (!in_valid || in_ready) begin
				if (report_queue.size() == 0) begin
					in_valid <= 1'b0;
				end else if (gap_count < report_queue[0].gap ||
						(report_queue[0].drain && n_checked != n_predicted)) begin
					gap_count++;
					in_valid <= 1'b0;
				end else begin
					next_report = report_queue.pop_front();
					motion_x  <= next_report.mx;
					motion_y  <= next_report.my;
					wheel_h   <= next_report.wh;
					wheel_v   <= next_report.wv;
					in_valid  <= 1'b1;
					gap_count = 0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				mon_got = {out_x, out_y, out_h, out_v};
				if (predicted_reports.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display("result with no report pending: x=%0d y=%0d h=%0d v=%0d",
							mon_got.x, mon_got.y, mon_got.h, mon_got.v);
				end else begin
					mon_want = predicted_reports.pop_front();
					if (mon_got !== mon_want) begin
						n_fail++;
						if (n_fail <= 10)
							$display("mismatch on report %0d: expected x=%0d y=%0d h=%0d v=%0d, got x=%0d y=%0d h=%0d v=%0d",
								n_checked, mon_want.x, mon_want.y, mon_want.h, mon_want.v,
								mon_got.x, mon_got.y, mon_got.h, mon_got.v);
					end
					n_checked <= n_checked + 1;
				end
				stall_left = rx_idle ? $urandom_range(0, 9) : 0;
			end
			if (long_hold_req != long_hold_seen) begin
				long_hold_seen = long_hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reports outstanding",
				cycle_count, n_predicted - n_checked + report_queue.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0: return 8'h80;
			1: return 8'h7f;
			2: return 8'($urandom_range(0, 8) - 4);
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic add_report(input logic [7:0] mx, input logic [7:0] my, input logic [7:0] wh,
			input logic [7:0] wv, input bit drain);
		report_in_t r;
		r.mx = mx;
		r.my = my;
		r.wh = wh;
		r.wv = wv;
		r.gap = tx_idle ? $urandom_range(0, 9) : 0;
		r.drain = drain;
		report_queue.push_back(r);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (report_queue.size() != 0 || in_valid || n_checked != n_predicted);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			trs_pkg::REG_ROTATION_INDEX: rot_sel = val;
			trs_pkg::REG_SCROLL_DIVIDER: div_sel = val[2:0];
			trs_pkg::REG_SCROLL_NEGATE:  neg_sel = val[0];
			trs_pkg::REG_SCROLL_MODE:    scroll_on = val[0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [3:0] rot, input logic [2:0] div, input bit neg,
			input bit mode, input bit tx_on, input bit rx_on);
		wait_idle();
		repeat (4) @(posedge clk);
		write_reg(trs_pkg::REG_ROTATION_INDEX, rot);
		write_reg(trs_pkg::REG_SCROLL_DIVIDER, {1'b0, div});
		write_reg(trs_pkg::REG_SCROLL_NEGATE, {3'b000, neg});
		write_reg(trs_pkg::REG_SCROLL_MODE, {3'b000, mode});
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		tx_idle = tx_on;
		rx_idle = rx_on;
		n_configs++;
	endtask

	task automatic run_random(input int n, input logic [3:0] rot, input logic [2:0] div,
			input bit neg, input bit mode, input bit tx_on, input bit rx_on, input bit burst);
		set_config(rot, div, neg, mode, tx_on, rx_on);
		// receiver holds off while the sender keeps offering items back to back
		if (burst)
			long_hold_req++;
		for (int i = 0; i < n; i++)
			add_report(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
				(i == 10) || ($urandom_range(0, 24) == 0));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: -45 degrees, pointer mode, field extremes
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		n_configs = 1;
		add_report(0, 0, 0, 0, 0);
		add_report(127, 127, -128, 127, 0);
		add_report(-128, -128, 127, -128, 0);
		add_report(127, -128, 1, -1, 0);
		add_report(-128, 127, 0, 0, 0);
		add_report(1, -1, 5, -5, 0);

		// indexes beyond the tables saturate
		set_config(15, 7, 0, 0, 0, 1);
		add_report(127, 0, 3, 4, 0);
		add_report(0, 127, -3, -4, 0);
		add_report(-128, -128, 0, 0, 0);

		// scroll at zero degrees, shift 1: ties, pass-through of -128, clamps
		set_config(4, 0, 0, 1, 1, 0);
		add_report(5, 5, 0, 0, 0);
		add_report(5, -5, 0, 0, 0);
		add_report(100, 3, 0, 0, 0);
		add_report(0, 0, -128, -128, 0);
		add_report(127, 0, 127, 0, 0);
		add_report(-128, 0, -128, 0, 0);
		add_report(0, -128, 0, 127, 0);

		set_config(0, 5, 1, 1, 1, 1);
		add_report(127, -128, 0, 0, 0);
		add_report(-128, 127, -128, 127, 0);
		add_report(64, -64, 3, -3, 0);

		run_random(48, 8, 5, 0, 1, 1, 1, 0);
		run_random(48, 0, 0, 1, 1, 0, 0, 0);
		run_random(48, 9, 6, 1, 1, 1, 1, 0);
		run_random(48, 2, 3, 0, 0, 1, 1, 0);
		run_random(48, 6, 1, 1, 1, 0, 0, 1);
		run_random(48, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
			1'($urandom_range(0, 1)), 1, 1, 1, 0);
		run_random(48, 7, 2, 0, 1, 0, 1, 0);

		// wheel pinned at 127 so nothing is drawn off: the horizontal accumulator wraps
		set_config(4, 5, 0, 1, 1, 1);
		for (int i = 0; i < 300; i++)
			add_report(8'($urandom_range(100, 127)), 8'($urandom_range(0, 8) - 4), 8'h7f,
				rand_byte(), $urandom_range(0, 24) == 0);

		wait_idle();
		repeat (8) @(posedge clk);
		@(negedge clk);
		$display("Run covered %0d reports over %0d register settings: pointer and scroll modes,",
			n_predicted, n_configs);
		$display("out-of-range indexes, clamping, accumulator wrap and back-pressure; %0d failures",
			n_fail);
		if (n_fail == 0 && predicted_reports.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
